// ===== rtl/scla_pkg.sv =====
`timescale 1ns / 1ps
package scla_pkg;

  localparam int NUM_LOCKERS_DEF = 64;
  localparam int NUM_CLASSES     = 21;
  localparam int CLS_W           = 5;

  localparam int VOL_W    = 12;
  localparam int TICKET_W = 6;
  localparam int STATUS_W = 2;
  localparam int LITRES_W = 8;
  localparam int FREE_W   = 7;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd3;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam int MIN_LITRES  = 5;
  localparam int STEP_LITRES = 10;
  localparam int MAX_LITRES  = 200;

  // v / 10 for v below 200 as (v * 205) >> 11
  localparam int SMALL_VOL_W  = 8;
  localparam int RECIP_10     = 205;
  localparam int RECIP_SHIFT  = 11;
  localparam int RECIP_PROD_W = 16;

  localparam int TICKET_FOLDS = ((2 ** TICKET_W) - 1) / NUM_CLASSES;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [CLS_W-1:0] cls;
  } cls_cmd_t;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic occ_we;
    logic occ_bit;
  } mem_cmd_t;

  function automatic logic [CLS_W-1:0] class_of_ticket(input logic [TICKET_W-1:0] ticket);
    logic [TICKET_W-1:0] x;
    x = ticket;
    for (int k = 0; k < TICKET_FOLDS; k++) begin
      if (x >= TICKET_W'(NUM_CLASSES)) x = x - TICKET_W'(NUM_CLASSES);
    end
    return x[CLS_W-1:0];
  endfunction

  function automatic logic [LITRES_W-1:0] litres_of_class(input logic [CLS_W-1:0] cls);
    if (cls == '0) return LITRES_W'(MIN_LITRES);
    return LITRES_W'(cls) * LITRES_W'(STEP_LITRES);
  endfunction

endpackage

// ===== rtl/scla_slot_mem.sv =====
`timescale 1ns / 1ps
module scla_slot_mem #(
  parameter int NUM_LOCKERS = scla_pkg::NUM_LOCKERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  scla_pkg::mem_cmd_t             cmd,
  input  logic [$clog2(NUM_LOCKERS)-1:0] rd_addr,
  input  logic [$clog2(NUM_LOCKERS)-1:0] link_waddr,
  input  logic [$clog2(NUM_LOCKERS)-1:0] link_wdata,
  input  logic [$clog2(NUM_LOCKERS)-1:0] occ_waddr,
  output logic [$clog2(NUM_LOCKERS)-1:0] link_rdata,
  output logic                           occ_rdata,
  output logic                           init_busy
);
  import scla_pkg::*;

  localparam int SW = $clog2(NUM_LOCKERS);

  logic [SW-1:0] link_mem [NUM_LOCKERS];
  logic          occ_mem  [NUM_LOCKERS];

  logic [SW-1:0] init_idx;
  logic [31:0]   init_link;

  logic          l_we;
  logic [SW-1:0] l_addr;
  logic [SW-1:0] l_data;
  logic          o_we;
  logic [SW-1:0] o_addr;
  logic          o_bit;

  // reset chain: each slot points at the next slot of its class
  assign init_link = 32'(init_idx) + 32'(NUM_CLASSES);

  always_comb begin
    if (init_busy) begin
      l_we   = 1'b1;
      l_addr = init_idx;
      l_data = init_link[SW-1:0];
      o_we   = 1'b1;
      o_addr = init_idx;
      o_bit  = 1'b0;
    end else begin
      l_we   = cmd.link_we;
      l_addr = link_waddr;
      l_data = link_wdata;
      o_we   = cmd.occ_we;
      o_addr = occ_waddr;
      o_bit  = cmd.occ_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      init_idx  <= '0;
    end else if (init_busy) begin
      if (init_idx == SW'(NUM_LOCKERS - 1)) begin
        init_busy <= 1'b0;
      end else begin
        init_idx <= init_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) link_mem[l_addr] <= l_data;
    if (cmd.rd_en) link_rdata <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (o_we) occ_mem[o_addr] <= o_bit;
    if (cmd.rd_en) occ_rdata <= occ_mem[rd_addr];
  end

endmodule

// ===== rtl/scla_class_tab.sv =====
`timescale 1ns / 1ps
module scla_class_tab #(
  parameter int NUM_LOCKERS = scla_pkg::NUM_LOCKERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [scla_pkg::CLS_W-1:0]     start_cls,
  output logic                           found,
  output logic [scla_pkg::CLS_W-1:0]     found_cls,
  input  logic [scla_pkg::CLS_W-1:0]     rd_cls,
  output logic [$clog2(NUM_LOCKERS)-1:0] rd_head,
  output logic [$clog2(NUM_LOCKERS)-1:0] rd_tail,
  output logic                           rd_nonempty,
  input  scla_pkg::cls_cmd_t             cmd,
  input  logic [$clog2(NUM_LOCKERS)-1:0] push_slot,
  input  logic [$clog2(NUM_LOCKERS)-1:0] pop_link
);
  import scla_pkg::*;

  localparam int SW      = $clog2(NUM_LOCKERS);
  localparam int FULL_Q  = NUM_LOCKERS / NUM_CLASSES;
  localparam int EXTRA_R = NUM_LOCKERS % NUM_CLASSES;

  logic [SW-1:0]          head [NUM_CLASSES];
  logic [SW-1:0]          tail [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] nonempty;
  logic [NUM_CLASSES-1:0] cand;

  // first non-empty class at or above the start class
  always_comb begin
    found_cls = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cand[k] = nonempty[k] && (CLS_W'(k) >= start_cls);
    end
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (cand[k]) found_cls = CLS_W'(k);
    end
    found = |cand;
  end

  assign rd_head     = head[rd_cls];
  assign rd_tail     = tail[rd_cls];
  assign rd_nonempty = nonempty[rd_cls];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= SW'(c);
        tail[c] <= (c < EXTRA_R) ? SW'(c + NUM_CLASSES * FULL_Q)
                                 : SW'(c + NUM_CLASSES * (FULL_Q - 1));
      end
      nonempty <= '1;
    end else if (cmd.pop) begin
      head[cmd.cls] <= pop_link;
      if (head[cmd.cls] == tail[cmd.cls]) nonempty[cmd.cls] <= 1'b0;
    end else if (cmd.push) begin
      if (!nonempty[cmd.cls]) head[cmd.cls] <= push_slot;
      tail[cmd.cls]     <= push_slot;
      nonempty[cmd.cls] <= 1'b1;
    end
  end

endmodule

// ===== rtl/size_class_locker_allocator.sv =====
`timescale 1ns / 1ps
// Locker allocator with 21 size classes (5, 10, 20 ... 200 litres); slot i is in
// class i mod 21 and each class hands out its free slots oldest first. One request
// word in gives one result word out. After reset the slot memory initializes every
// slot, and in_stall stays high until that is done and the control has gone idle.
// An allocate that gets a slot then passes accept, class search, pop through the
// registered read of the slot link memory, and output load; one that fails passes
// accept, class search and output load, and a release passes accept with the
// occupancy read, list update and output load. One request is worked on at a time;
// a finished result sits in the output register so the next request can be accepted
// while it waits to be taken.
module size_class_locker_allocator #(
  parameter int NUM_LOCKERS = scla_pkg::NUM_LOCKERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [scla_pkg::VOL_W-1:0]    volume_litres,
  input  logic [scla_pkg::TICKET_W-1:0] slot_to_release,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scla_pkg::STATUS_W-1:0] status,
  output logic [scla_pkg::TICKET_W-1:0] slot_index,
  output logic [scla_pkg::LITRES_W-1:0] class_litres,
  output logic [scla_pkg::FREE_W-1:0]   free_slots
);
  import scla_pkg::*;

  localparam int SW = $clog2(NUM_LOCKERS);
  localparam int FW = $clog2(NUM_LOCKERS + 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_REL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state;
  logic [CLS_W-1:0]    start_cls;
  logic                none_fit;
  logic                too_big;
  logic [SW-1:0]       rel_slot;
  logic [CLS_W-1:0]    rel_cls;
  logic                rel_in_range;
  logic [CLS_W-1:0]    cur_cls;
  logic [SW-1:0]       cur_slot;
  logic [FW-1:0]       free_cnt;
  logic [STATUS_W-1:0] res_status;
  logic [SW-1:0]       res_slot;
  logic [LITRES_W-1:0] res_litres;

  logic                    accept;
  logic [RECIP_PROD_W-1:0] tens_prod;
  logic [CLS_W-1:0]        start_in;
  logic [31:0]             ticket_wide;
  logic                    ticket_ok;
  logic [31:0]             res_slot_wide;
  logic [31:0]             free_wide;
  logic                    out_free;

  logic             found;
  logic [CLS_W-1:0] found_cls;
  logic [CLS_W-1:0] rd_cls;
  logic [SW-1:0]    rd_head;
  logic [SW-1:0]    rd_tail;
  logic             rd_nonempty;
  cls_cmd_t         cls_cmd;

  mem_cmd_t         mem_cmd;
  logic [SW-1:0]    mem_rd_addr;
  logic [SW-1:0]    occ_waddr;
  logic [SW-1:0]    link_rdata;
  logic             occ_rdata;
  logic             init_busy;
  logic             rel_good;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // start class: below 5 litres the smallest class, else v/10 + 1
  assign tens_prod = RECIP_PROD_W'(volume_litres[SMALL_VOL_W-1:0]) * RECIP_PROD_W'(RECIP_10);
  assign start_in  = (volume_litres < VOL_W'(MIN_LITRES)) ? '0
                   : tens_prod[RECIP_SHIFT +: CLS_W] + 1'b1;

  assign ticket_wide = 32'(slot_to_release);
  assign ticket_ok   = (ticket_wide < 32'(NUM_LOCKERS));
  assign rel_good    = rel_in_range && occ_rdata;

  always_comb begin
    unique case (state)
      S_LOOK:  rd_cls = found_cls;
      S_POP:   rd_cls = cur_cls;
      default: rd_cls = rel_cls;
    endcase
  end

  always_comb begin
    mem_cmd     = '0;
    mem_rd_addr = rel_slot;
    occ_waddr   = rel_slot;
    cls_cmd     = '0;
    unique case (state)
      S_IDLE: begin
        mem_cmd.rd_en = accept && (action == ACT_RELEASE) && ticket_ok;
        mem_rd_addr   = ticket_wide[SW-1:0];
      end
      S_LOOK: begin
        if (!none_fit && found) begin
          mem_cmd.rd_en   = 1'b1;
          mem_cmd.occ_we  = 1'b1;
          mem_cmd.occ_bit = 1'b1;
          mem_rd_addr     = rd_head;
          occ_waddr       = rd_head;
        end
      end
      S_POP: begin
        cls_cmd.pop = 1'b1;
        cls_cmd.cls = cur_cls;
      end
      S_REL: begin
        if (rel_good) begin
          mem_cmd.occ_we  = 1'b1;
          mem_cmd.occ_bit = 1'b0;
          mem_cmd.link_we = rd_nonempty;
          cls_cmd.push    = 1'b1;
          cls_cmd.cls     = rel_cls;
        end
      end
      default: begin
      end
    endcase
  end

  scla_class_tab #(
    .NUM_LOCKERS(NUM_LOCKERS)
  ) u_class_tab (
    .clk        (clk),
    .rst        (rst),
    .start_cls  (start_cls),
    .found      (found),
    .found_cls  (found_cls),
    .rd_cls     (rd_cls),
    .rd_head    (rd_head),
    .rd_tail    (rd_tail),
    .rd_nonempty(rd_nonempty),
    .cmd        (cls_cmd),
    .push_slot  (rel_slot),
    .pop_link   (link_rdata)
  );

  scla_slot_mem #(
    .NUM_LOCKERS(NUM_LOCKERS)
  ) u_slot_mem (
    .clk       (clk),
    .rst       (rst),
    .cmd       (mem_cmd),
    .rd_addr   (mem_rd_addr),
    .link_waddr(rd_tail),
    .link_wdata(rel_slot),
    .occ_waddr (occ_waddr),
    .link_rdata(link_rdata),
    .occ_rdata (occ_rdata),
    .init_busy (init_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      free_cnt <= FW'(NUM_LOCKERS);
    end else begin
      unique case (state)
        S_INIT: begin
          if (!init_busy) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= (action == ACT_RELEASE) ? S_REL : S_LOOK;
        end
        S_LOOK: begin
          if (!none_fit && found) begin
            free_cnt <= free_cnt - 1'b1;
            state    <= S_POP;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP: state <= S_DONE;
        S_REL: begin
          if (rel_good) free_cnt <= free_cnt + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      start_cls    <= start_in;
      none_fit     <= (volume_litres >= VOL_W'(MAX_LITRES));
      too_big      <= (volume_litres > VOL_W'(MAX_LITRES));
      rel_slot     <= ticket_wide[SW-1:0];
      rel_cls      <= class_of_ticket(slot_to_release);
      rel_in_range <= ticket_ok;
    end
    if (state == S_LOOK) begin
      cur_cls    <= found_cls;
      cur_slot   <= rd_head;
      res_status <= too_big ? ST_TOO_LARGE : ST_FULL;
      res_slot   <= '0;
      res_litres <= '0;
    end
    if (state == S_POP) begin
      res_status <= ST_OK;
      res_slot   <= cur_slot;
      res_litres <= litres_of_class(cur_cls);
    end
    if (state == S_REL) begin
      res_status <= rel_good ? ST_OK : ST_BAD_RELEASE;
      res_slot   <= rel_good ? rel_slot : '0;
      res_litres <= rel_good ? litres_of_class(rel_cls) : '0;
    end
  end

  assign res_slot_wide = 32'(res_slot);
  assign free_wide     = 32'(free_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status       <= res_status;
      slot_index   <= res_slot_wide[TICKET_W-1:0];
      class_litres <= res_litres;
      free_slots   <= free_wide[FREE_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_init_blocks_input: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> in_stall)
    else $error("request accepted during slot memory initialization");

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(free_cnt) <= 32'(NUM_LOCKERS))
    else $error("free slot count above the number of slots");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> rd_nonempty)
    else $error("pop from an empty class list");

  a_ok_has_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (class_litres != '0))
    else $error("granted or freed slot reported without a size class");
`endif

endmodule

// ===== test/tb_size_class_locker_allocator.sv =====
`timescale 1ns / 1ps
module tb_size_class_locker_allocator;
  import scla_pkg::*;

  localparam int LOCKERS      = NUM_LOCKERS_DEF;
  localparam int RANDOM_WORDS = 1200;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] slot;
    logic [LITRES_W-1:0] litres;
    logic [FREE_W-1:0]   free;
  } locker_result_t;

  logic                clk             = 1'b0;
  logic                rst             = 1'b1;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic                action          = ACT_ALLOC;
  logic [VOL_W-1:0]    volume_litres   = '0;
  logic [TICKET_W-1:0] slot_to_release = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [TICKET_W-1:0] slot_index;
  logic [LITRES_W-1:0] class_litres;
  logic [FREE_W-1:0]   free_slots;

  // locker state as the block should hold it
  logic [TICKET_W-1:0] free_link [LOCKERS];
  logic [TICKET_W-1:0] list_head [NUM_CLASSES];
  logic [TICKET_W-1:0] list_tail [NUM_CLASSES];
  logic [FREE_W-1:0]   list_len [NUM_CLASSES];
  logic                occupied [LOCKERS];
  logic [FREE_W-1:0]   lockers_used;

  locker_result_t pending_results [$];

  int   errors         = 0;
  int   cycles         = 0;
  int   stall_left     = 0;
  int   n_granted      = 0;
  int   n_full         = 0;
  int   n_too_large    = 0;
  int   n_freed        = 0;
  int   n_bad_release  = 0;
  logic calm           = 1'b0;
  logic hold_off       = 1'b0;

  size_class_locker_allocator #(.NUM_LOCKERS(LOCKERS)) i_dut (.*);

  always #4 clk = ~clk;

  function automatic void reset_lockers();
    int c;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      list_len[k]  = '0;
      list_head[k] = '0;
      list_tail[k] = '0;
    end
    for (int i = 0; i < LOCKERS; i++) begin
      c = i % NUM_CLASSES;
      occupied[i]  = 1'b0;
      free_link[i] = '0;
      if (list_len[c] == 0) list_head[c] = TICKET_W'(i);
      else free_link[list_tail[c]] = TICKET_W'(i);
      list_tail[c] = TICKET_W'(i);
      list_len[c]  = list_len[c] + 1'b1;
    end
    lockers_used = '0;
  endfunction

  function automatic logic [LITRES_W-1:0] class_size(int cls);
    return (cls == 0) ? LITRES_W'(MIN_LITRES) : LITRES_W'(STEP_LITRES * cls);
  endfunction

  // applies one request to the locker state and returns the word it should produce
  function automatic locker_result_t serve_request(logic act, logic [VOL_W-1:0] vol,
                                                   logic [TICKET_W-1:0] ticket);
    locker_result_t r;
    int             cls;
    int             s;
    r.status = ST_OK;
    r.slot   = '0;
    r.litres = '0;
    if (act == ACT_ALLOC) begin
      cls = (vol < MIN_LITRES) ? 0 : int'(vol) / STEP_LITRES + 1;
      while (cls < NUM_CLASSES && list_len[cls] == 0) cls++;
      if (cls >= NUM_CLASSES) begin
        r.status = (vol <= MAX_LITRES) ? ST_FULL : ST_TOO_LARGE;
      end else begin
        s              = list_head[cls];
        list_head[cls] = free_link[s];
        list_len[cls]  = list_len[cls] - 1'b1;
        occupied[s]    = 1'b1;
        lockers_used   = lockers_used + 1'b1;
        r.slot         = TICKET_W'(s);
        r.litres       = class_size(cls);
      end
    end else if (!occupied[ticket]) begin
      r.status = ST_BAD_RELEASE;
    end else begin
      cls              = ticket % NUM_CLASSES;
      occupied[ticket] = 1'b0;
      if (list_len[cls] == 0) list_head[cls] = ticket;
      else free_link[list_tail[cls]] = ticket;
      list_tail[cls] = ticket;
      list_len[cls]  = list_len[cls] + 1'b1;
      if (lockers_used != 0) lockers_used = lockers_used - 1'b1;
      r.slot   = ticket;
      r.litres = class_size(cls);
    end
    r.free = FREE_W'(LOCKERS - lockers_used);
    case (r.status)
      ST_OK:          if (act == ACT_ALLOC) n_granted++; else n_freed++;
      ST_FULL:        n_full++;
      ST_TOO_LARGE:   n_too_large++;
      ST_BAD_RELEASE: n_bad_release++;
      default:        ;
    endcase
    return r;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  task automatic send_word(logic act, logic [VOL_W-1:0] vol, logic [TICKET_W-1:0] ticket);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= act;
    volume_litres   <= vol;
    slot_to_release <= ticket;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(serve_request(act, vol, ticket));
  endtask

  // mostly well-formed traffic: volumes near the classes, releases of held slots
  task automatic send_random_word(int alloc_pct);
    int                  pick;
    int                  start;
    logic [VOL_W-1:0]    vol;
    logic [TICKET_W-1:0] ticket;
    if ($urandom_range(1, 100) <= alloc_pct) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) vol = VOL_W'($urandom_range(0, MAX_LITRES));
      else if (pick < 9) vol = VOL_W'($urandom_range(MAX_LITRES - 10, MAX_LITRES + 15));
      else vol = VOL_W'($urandom);
      send_word(ACT_ALLOC, vol, TICKET_W'($urandom));
    end else begin
      ticket = TICKET_W'($urandom);
      if ($urandom_range(0, 9) != 0) begin
        start = $urandom_range(0, LOCKERS - 1);
        for (int k = 0; k < LOCKERS; k++) begin
          if (occupied[(start + k) % LOCKERS]) begin
            ticket = TICKET_W'((start + k) % LOCKERS);
            break;
          end
        end
      end
      send_word(ACT_RELEASE, VOL_W'($urandom), ticket);
    end
  endtask

  task automatic test_volume_edges();
    int vols [11] = '{0, 4, 5, 9, 10, 199, 200, 201, 2730, 1365, 4095};
    foreach (vols[i]) send_word(ACT_ALLOC, VOL_W'(vols[i]), TICKET_W'($urandom));
  endtask

  task automatic test_release_cases();
    send_word(ACT_RELEASE, '0, TICKET_W'(0));
    send_word(ACT_RELEASE, '1, TICKET_W'(0));
    send_word(ACT_RELEASE, '0, TICKET_W'(LOCKERS - 1));
  endtask

  // drain the largest class, then check that freed slots come back oldest first
  task automatic test_class_exhaustion();
    repeat (3) send_word(ACT_ALLOC, VOL_W'(195), '0);
    send_word(ACT_RELEASE, '0, TICKET_W'(62));
    send_word(ACT_RELEASE, '0, TICKET_W'(20));
    repeat (2) send_word(ACT_ALLOC, VOL_W'(195), '0);
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (30) send_random_word(60);
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int alloc_pct;
    int pcts [3] = '{85, 50, 20};
    alloc_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // shift the alloc/release mix so the pools fill up and drain again
      if (n % 100 == 0) begin
        alloc_pct = pcts[$urandom_range(0, 2)];
        calm      = ($urandom_range(0, 3) == 0);
      end
      send_random_word(alloc_pct);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", int'(status), 0);
      end else begin
        locker_result_t want;
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (slot_index !== want.slot) report_mismatch("slot_index", slot_index, want.slot);
        if (class_litres !== want.litres)
          report_mismatch("class_litres", class_litres, want.litres);
        if (free_slots !== want.free) report_mismatch("free_slots", free_slots, want.free);
      end
      stall_left = draw_wait();
    end
    out_stall <= hold_off || stall_left > 0;
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    reset_lockers();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_volume_edges();
    test_release_cases();
    test_class_exhaustion();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("allocations: %0d granted, %0d all full, %0d too large",
             n_granted, n_full, n_too_large);
    $display("releases: %0d freed, %0d invalid; one output hold of %0d cycles",
             n_freed, n_bad_release, HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== size_class_locker_allocator.f =====
rtl/scla_pkg.sv
rtl/scla_slot_mem.sv
rtl/scla_class_tab.sv
rtl/size_class_locker_allocator.sv
test/tb_size_class_locker_allocator.sv
